// ===== hdl/gbba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbba_pkg
// Types and constants shared by the grouped bitmap block allocator.
// ----------------------------------------------------------------------------
package gbba_pkg;

    // input word kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_BLOCKS_PER_GROUP = 2'd0;
    localparam logic [1:0] CFG_GROUP_COUNT      = 2'd1;
    localparam logic [1:0] CFG_INODES_PER_GROUP = 2'd2;

    localparam int CFG_DATA_W = 17;

    localparam logic [15:0] RST_BLOCKS_PER_GROUP = 16'd8192;
    localparam logic [12:0] RST_GROUP_COUNT      = 13'd16;
    localparam logic [16:0] RST_INODES_PER_GROUP = 17'd2048;

    // scan index width: group count times words per group
    localparam int SCAN_W = 24;

    typedef struct packed {
        logic        kind;
        logic [11:0] word_address;
        logic [31:0] word_value;
        logic [31:0] hint_inode;
    } t_in_word;

    typedef struct packed {
        logic        found;
        logic [16:0] block_number;
    } t_out_word;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_stat;

    // position of the lowest clear bit; 31 when every bit is set
    function automatic logic [4:0] lowest_clear(input logic [31:0] w);
        logic [4:0] b;
        b = 5'd31;
        for (int i = 31; i >= 0; i--) begin
            if (!w[i]) begin
                b = 5'(i);
            end
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/gbba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbba_ram
// Usage bitmap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbba_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hdl/gbba_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbba_div
// Restoring divider, one quotient bit per cycle, 32 quotient bits per division.
// ----------------------------------------------------------------------------
module gbba_div
    import gbba_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [16:0] i_divisor,
    output t_div_stat        o_stat
);

    logic [16:0] r_rem;
    logic [31:0] r_q;
    logic [16:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [17:0] trial;
    logic        fits;

    always_comb begin
        trial = {r_rem, r_q[31]};
        fits  = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // shift the dividend out as quotient bits come in
                r_rem <= fits ? 17'(trial - {1'b0, r_div}) : trial[16:0];
                r_q   <= {r_q[30:0], fits};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_q;

endmodule
`default_nettype wire

// ===== hdl/grouped_bitmap_block_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator_core
// Block allocator over a usage bitmap with a group hint.
// ----------------------------------------------------------------------------
// One item is worked at a time. After reset the bitmap is cleared one word a
// cycle, and the input stalls until the clearing is done (configuration writes
// are taken throughout). A load goes to S_RESP, which registers its result once
// the output is free. An allocation first runs the serial divider that maps
// the hint inode to its start group (32 steps and the hand-off), then S_MUL
// does the group multiplies, then S_SCAN reads one bitmap word per cycle from
// the single read port, keeping one read in flight ahead of the check, and
// S_RESP presents the result. A start group past the end skips the scan, and
// a scan that runs out reports no block.
// The next word is accepted in the cycle after the result is registered.
// ----------------------------------------------------------------------------
module grouped_bitmap_block_allocator_core
    import gbba_pkg::*;
#(
    parameter int BITMAP_WORDS = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_word              i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_word                  o_out_word,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam logic [SCAN_W-1:0] WORDS_L = SCAN_W'(BITMAP_WORDS);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_DIV, S_MUL, S_SCAN, S_RESP
    } t_state;

    t_state            r_state;
    logic [15:0]       r_bpg;
    logic [12:0]       r_gc;
    logic [16:0]       r_ipg;
    logic              r_zero_div;
    logic [SCAN_W-1:0] r_idx;
    logic [SCAN_W-1:0] r_end;
    logic [SCAN_W-1:0] r_chk_idx;
    logic              r_chk_valid;
    t_out_word         r_res;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic              in_acc;
    logic              div_start;
    t_div_stat         div_stat;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [31:0]       ram_wdata;
    logic              ram_re;
    logic [31:0]       ram_rdata;
    logic [SCAN_W-1:0] ld_addr;
    logic [10:0]       wpg;
    logic [31:0]       start_grp;
    logic              start_ok;
    logic              issue;
    logic              hit;
    logic [4:0]        hit_bit;
    logic              out_free;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign div_start  = in_acc && (i_in_word.kind == KIND_ALLOC);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        ld_addr   = SCAN_W'(i_in_word.word_address);
        wpg       = r_bpg[15:5];
        start_grp = r_zero_div ? 32'd0 : div_stat.quotient;
        start_ok  = start_grp < 32'(r_gc);
        issue     = (r_idx < r_end) && (r_idx < WORDS_L);
        hit       = r_chk_valid && (ram_rdata != '1);
        hit_bit   = lowest_clear(ram_rdata);
    end

    // memory port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                ram_we    = in_acc && (i_in_word.kind == KIND_LOAD)
                            && (ld_addr < WORDS_L);
                ram_waddr = ld_addr[AW-1:0];
                ram_wdata = i_in_word.word_value;
            end
            S_SCAN: begin
                ram_re    = issue;
                ram_we    = hit;
                ram_waddr = r_chk_idx[AW-1:0];
                ram_wdata = ram_rdata | (32'd1 << hit_bit);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_bpg       <= RST_BLOCKS_PER_GROUP;
            r_gc        <= RST_GROUP_COUNT;
            r_ipg       <= RST_INODES_PER_GROUP;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLOCKS_PER_GROUP: r_bpg <= i_cfg_data[15:0];
                    CFG_GROUP_COUNT:      r_gc  <= i_cfg_data[12:0];
                    CFG_INODES_PER_GROUP: r_ipg <= i_cfg_data[16:0];
                    default: ;
                endcase
            end

            // drop a taken word; S_RESP loads the next one itself
            if (r_out_valid && !i_out_stall && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + SCAN_W'(1);
                    if (r_idx == WORDS_L - SCAN_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_res      <= '0;
                        r_zero_div <= (r_ipg == '0);
                        r_state    <= (i_in_word.kind == KIND_LOAD) ? S_RESP : S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_idx       <= SCAN_W'(start_grp[12:0]) * SCAN_W'(wpg);
                    r_end       <= SCAN_W'(r_gc) * SCAN_W'(wpg);
                    r_chk_valid <= 1'b0;
                    r_state     <= start_ok ? S_SCAN : S_RESP;
                end
                S_SCAN: begin
                    if (hit) begin
                        r_res.found        <= 1'b1;
                        r_res.block_number <= {r_chk_idx[11:0], hit_bit};
                        r_state            <= S_RESP;
                    end else if (!issue && !r_chk_valid) begin
                        r_state <= S_RESP;
                    end else begin
                        // keep one read in flight ahead of the check
                        r_idx       <= r_idx + SCAN_W'(issue);
                        r_chk_valid <= issue;
                        r_chk_idx   <= r_idx;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    gbba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in_word.hint_inode - 32'd1),
        .i_divisor  (r_ipg),
        .o_stat     (div_stat)
    );

    gbba_ram #(
        .DEPTH (BITMAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// ===== hdl/gbba_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbba_checker
// Port-level checks for the grouped bitmap block allocator.
// ----------------------------------------------------------------------------
module gbba_checker
    import gbba_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire t_out_word             o_out_word
);

    // clearing pass holds the input off right after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // one word at a time: an accepted word blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word accepted while one is in flight");

    // a miss or a load always reports block zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.found) |-> (o_out_word.block_number == '0))
        else $error("nonzero block number without a claim");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result changed");

endmodule

bind grouped_bitmap_block_allocator_core gbba_checker u_gbba_checker (.*);
`default_nettype wire
